// ===== src/tbl_pkg.sv =====
// Shared types and constants for the token boundary lexer.
package tbl_pkg;

  typedef logic [1:0] byte_kind_t;

  localparam byte_kind_t KIND_SPACE  = 2'd0;
  localparam byte_kind_t KIND_SPLIT  = 2'd1;
  localparam byte_kind_t KIND_STRING = 2'd2;
  localparam byte_kind_t KIND_WORD   = 2'd3;

  typedef struct packed {
    logic in_string;
    logic quote_is_double;
    logic escape_pending;
    logic in_bare_word;
  } lex_state_t;

  localparam lex_state_t LEX_STATE_RESET = '{1'b0, 1'b0, 1'b0, 1'b0};

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

// ===== src/tbl_classify.sv =====
// Byte classifier and lexer state next-value logic.
module tbl_classify
  import tbl_pkg::*;
(
  input  lex_state_t state,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output byte_kind_t byte_kind,
  output logic       token_start,
  output logic       unterminated,
  output lex_state_t state_nxt
);

  logic       is_space;
  logic       is_split;
  logic       is_quote;
  logic [7:0] close_quote;
  lex_state_t upd;

  assign is_space = (data_byte == CH_LF) || (data_byte == CH_CR) ||
                    (data_byte == CH_TAB) || (data_byte == CH_SPACE);
  assign is_split = (data_byte == CH_COMMA) || (data_byte == CH_SEMI) ||
                    (data_byte == CH_COLON) || (data_byte == CH_LBRACK) ||
                    (data_byte == CH_RBRACK) || (data_byte == CH_LPAREN) ||
                    (data_byte == CH_RPAREN) || (data_byte == CH_LBRACE) ||
                    (data_byte == CH_RBRACE);
  assign is_quote    = (data_byte == CH_DQUOTE) || (data_byte == CH_SQUOTE);
  assign close_quote = state.quote_is_double ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    upd         = state;
    byte_kind   = KIND_WORD;
    token_start = 1'b0;
    if (state.in_string) begin
      byte_kind = KIND_STRING;
      if (data_byte == close_quote) begin
        if (state.escape_pending) begin
          upd.escape_pending = 1'b0;
        end else begin
          upd.in_string = 1'b0;
        end
      end else if (data_byte == CH_BSLASH) begin
        upd.escape_pending = !state.escape_pending;
      end else begin
        upd.escape_pending = 1'b0;
      end
    end else if (is_space) begin
      byte_kind        = KIND_SPACE;
      upd.in_bare_word = 1'b0;
    end else if (is_split) begin
      byte_kind        = KIND_SPLIT;
      token_start      = 1'b1;
      upd.in_bare_word = 1'b0;
    end else if (state.in_bare_word) begin
      byte_kind = KIND_WORD;
    end else if (is_quote) begin
      byte_kind           = KIND_STRING;
      token_start         = 1'b1;
      upd.in_string       = 1'b1;
      upd.quote_is_double = (data_byte == CH_DQUOTE);
      upd.escape_pending  = 1'b0;
    end else begin
      byte_kind        = KIND_WORD;
      token_start      = 1'b1;
      upd.in_bare_word = 1'b1;
    end
  end

  assign unterminated = last_byte && upd.in_string;
  assign state_nxt    = last_byte ? LEX_STATE_RESET : upd;

endmodule

// ===== src/token_boundary_lexer.sv =====
// Token boundary lexer top level: input register, classifier, result register.
// Takes one byte per transaction and returns one tagged byte per transaction,
// in order. Each byte passes through an input register and a result register
// before it appears at the output; with the output taken every cycle the block
// sustains one byte per cycle. Lexer state is updated as a byte moves from the
// input register into the result register, and returns to its reset value after
// a byte marked last.
module token_boundary_lexer
  import tbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_byte_kind,
  output logic       out_token_start,
  output logic       out_last,
  output logic       out_unterminated
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  byte_kind_t out_kind_r;
  logic       out_start_r;
  logic       out_last_r;
  logic       out_unterm_r;
  lex_state_t state_r, state_nxt;

  byte_kind_t c_kind;
  logic       c_start;
  logic       c_unterm;
  logic       out_free;
  logic       s1_fire;
  logic       in_fire;

  tbl_classify u_classify (
    .state        (state_r),
    .data_byte    (s1_byte_r),
    .last_byte    (s1_last_r),
    .byte_kind    (c_kind),
    .token_start  (c_start),
    .unterminated (c_unterm),
    .state_nxt    (state_nxt)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= LEX_STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_fire) begin
      out_byte_r   <= s1_byte_r;
      out_kind_r   <= c_kind;
      out_start_r  <= c_start;
      out_last_r   <= s1_last_r;
      out_unterm_r <= c_unterm;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_kind    = out_kind_r;
  assign out_token_start  = out_start_r;
  assign out_last         = out_last_r;
  assign out_unterminated = out_unterm_r;

  a_unterm_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_unterm_r |-> out_last_r)
    else $error("unterminated flag on a byte that is not last");

  a_space_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_SPACE) |-> !out_start_r)
    else $error("whitespace byte marked as token start");

  a_string_start_quote: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_start_r && (out_kind_r == KIND_STRING) |->
      (out_byte_r == CH_DQUOTE) || (out_byte_r == CH_SQUOTE))
    else $error("string token starts on a non-quote byte");

  a_state_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> state_r == LEX_STATE_RESET)
    else $error("lexer state not cleared after last byte");

  a_no_string_and_word: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.in_string && state_r.in_bare_word))
    else $error("string and bare word open at once");

endmodule
